/* rtl/rhni_pkg.sv */
// rhni_pkg: shared constants, types and decode helpers for the hazard nop inserter
// no dependencies
package rhni_pkg;

    localparam logic [31:0] NOP_WORD  = 32'h0000_0013;

    localparam logic [6:0]  OP_R      = 7'b0110011;
    localparam logic [6:0]  OP_IARITH = 7'b0010011;
    localparam logic [6:0]  OP_LOAD   = 7'b0000011;
    localparam logic [6:0]  OP_SYSTEM = 7'b1110011;
    localparam logic [6:0]  OP_JALR   = 7'b1100111;
    localparam logic [6:0]  OP_S      = 7'b0100011;
    localparam logic [6:0]  OP_B      = 7'b1100011;
    localparam logic [6:0]  OP_LUI    = 7'b0110111;
    localparam logic [6:0]  OP_AUIPC  = 7'b0010111;
    localparam logic [6:0]  OP_J      = 7'b1101111;

    localparam int unsigned JOB_DEPTH = 2;
    localparam int unsigned JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_NOPS   = 2'd1,
        MODE_SLOT   = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DECODED = 2'd0,
        KIND_NOP     = 2'd1,
        KIND_SLOT    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        FMT_R     = 3'd0,
        FMT_I     = 3'd1,
        FMT_S     = 3'd2,
        FMT_B     = 3'd3,
        FMT_U     = 3'd4,
        FMT_J     = 3'd5,
        FMT_OTHER = 3'd6
    } t_fmt;

    typedef struct packed {
        logic [31:0] word;
        t_kind       kind;
        logic        haz_near;
        logic        haz_far;
        logic        pre_nops;
        logic        post_nops;
    } t_job;

    function automatic t_fmt fmt_of(input logic [6:0] op);
        t_fmt f;
        case (op)
            OP_R:                                    f = FMT_R;
            OP_IARITH, OP_LOAD, OP_SYSTEM, OP_JALR:  f = FMT_I;
            OP_S:                                    f = FMT_S;
            OP_B:                                    f = FMT_B;
            OP_LUI, OP_AUIPC:                        f = FMT_U;
            OP_J:                                    f = FMT_J;
            default:                                 f = FMT_OTHER;
        endcase
        return f;
    endfunction

    function automatic logic [19:0] imm_of(input logic [31:0] word);
        logic [19:0] imm;
        case (fmt_of(word[6:0]))
            FMT_I:   imm = {8'd0, word[31:20]};
            FMT_U:   imm = word[31:12];
            default: imm = 20'd0;
        endcase
        return imm;
    endfunction

endpackage

/* rtl/rhni_if.sv */
// rhni_if: valid/ready channel interfaces for instruction input, result output and config
// depends on nothing but the port widths of the block
interface rhni_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rhni_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [31:0] out_word;
    logic [2:0]  format;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [19:0] imm_bits;
    logic        hazard_near;
    logic        hazard_far;
    logic        last;

    modport source (output valid, output item_kind, output out_word, output format,
                    output dest_reg, output src1_reg, output src2_reg, output imm_bits,
                    output hazard_near, output hazard_far, output last, input ready);
    modport sink   (input valid, input item_kind, input out_word, input format,
                    input dest_reg, input src1_reg, input src2_reg, input imm_bits,
                    input hazard_near, input hazard_far, input last, output ready);
endinterface

interface rhni_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] branch_mode;

    modport source (output valid, output branch_mode, input ready);
    modport sink   (input valid, input branch_mode, output ready);
endinterface

/* rtl/rhni_fifo.sv */
// rhni_fifo: short register queue of decoded jobs between front and back
// depends on rhni_pkg
module rhni_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rhni_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rhni_pkg::t_job o_data
);
    import rhni_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wptr, n_wptr;
    logic [JOB_PTR_W-1:0] r_rptr, n_rptr;
    logic [JOB_CNT_W-1:0] r_cnt, n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == JOB_CNT_W'(JOB_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

/* rtl/rhni_front.sv */
// rhni_front: accepts instruction beats, checks hazards and delay slots, queues jobs
// depends on rhni_pkg and rhni_if
module rhni_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rhni_in_if.sink          i_in,
    rhni_cfg_if.sink         i_cfg,
    input  logic             i_full,
    output logic             o_push,
    output rhni_pkg::t_job   o_job
);
    import rhni_pkg::*;

    t_mode       r_mode;
    logic [4:0]  r_dest0, n_dest0;
    logic [4:0]  r_dest1, n_dest1;
    logic        r_slot_pending, n_slot_pending;
    logic [9:0]  r_branch_src, n_branch_src;

    logic [31:0] w;
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [4:0]  u1, u2, b1, b2;
    logic        is_branch;
    logic        bad_slot;
    logic        accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign accept      = i_in.valid && !i_full;
    assign o_push      = accept;

    assign w         = i_in.instr_word;
    assign op        = w[6:0];
    assign rd        = w[11:7];
    assign rs1       = w[19:15];
    assign rs2       = w[24:20];
    assign is_branch = (op == OP_B) || (op == OP_J);
    assign b1        = r_branch_src[4:0];
    assign b2        = r_branch_src[9:5];

    always_comb begin
        u1 = '0;
        u2 = '0;
        if (op == OP_R || op == OP_IARITH || op == OP_LOAD || op == OP_S || op == OP_B) begin
            u1 = rs1;
        end
        if (op == OP_R || op == OP_S || op == OP_B) begin
            u2 = rs2;
        end
        bad_slot = is_branch || (w == NOP_WORD)
                || (u1 != '0 && (u1 == b1 || u1 == b2))
                || (u2 != '0 && (u2 == b1 || u2 == b2));
    end

    always_comb begin
        n_dest0        = r_dest0;
        n_dest1        = r_dest1;
        n_slot_pending = r_slot_pending;
        n_branch_src   = r_branch_src;
        o_job.word      = w;
        o_job.kind      = KIND_DECODED;
        o_job.haz_near  = 1'b0;
        o_job.haz_far   = 1'b0;
        o_job.pre_nops  = 1'b0;
        o_job.post_nops = 1'b0;
        if (r_slot_pending) begin
            o_job.kind     = KIND_SLOT;
            o_job.pre_nops = bad_slot;
            n_slot_pending = 1'b0;
        end else begin
            if (op == OP_R || op == OP_S) begin
                o_job.haz_near = (r_dest0 != '0) && (r_dest0 == rs1 || r_dest0 == rs2);
                o_job.haz_far  = (r_dest1 != '0) && (r_dest1 == rs1 || r_dest1 == rs2);
            end else if (op == OP_IARITH) begin
                o_job.haz_near = (r_dest0 != '0) && (r_dest0 == rs1);
                o_job.haz_far  = (r_dest1 != '0) && (r_dest1 == rs1);
            end
            n_dest1 = r_dest0;
            n_dest0 = (op == OP_R || op == OP_IARITH) ? rd : 5'd0;
            if (is_branch && r_mode == MODE_NOPS) begin
                o_job.post_nops = 1'b1;
            end
            if (is_branch && r_mode == MODE_SLOT) begin
                n_slot_pending = 1'b1;
                n_branch_src   = {rs2, rs1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NONE;
            r_dest0        <= '0;
            r_dest1        <= '0;
            r_slot_pending <= 1'b0;
            r_branch_src   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= t_mode'(i_cfg.branch_mode);
            end
            if (accept) begin
                r_dest0        <= n_dest0;
                r_dest1        <= n_dest1;
                r_slot_pending <= n_slot_pending;
                r_branch_src   <= n_branch_src;
            end
        end
    end
endmodule

/* rtl/rhni_back.sv */
// rhni_back: expands queued jobs into result beats with nop runs, output register
// depends on rhni_pkg and rhni_if
module rhni_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  rhni_pkg::t_job i_job,
    output logic           o_pop,
    rhni_out_if.source     o_out
);
    import rhni_pkg::*;

    logic [1:0]  r_step;
    logic        r_valid;
    t_kind       r_kind;
    logic [31:0] r_word;
    t_fmt        r_fmt;
    logic [19:0] r_imm;
    logic        r_hn;
    logic        r_hf;
    logic        r_last;

    logic        multi;
    logic        is_last;
    logic        is_nop;
    logic        advance;
    logic [31:0] n_word;

    assign multi   = i_job.pre_nops || i_job.post_nops;
    assign is_last = !multi || (r_step == 2'd3);
    assign is_nop  = i_job.pre_nops ? (r_step != 2'd3)
                   : (i_job.post_nops && r_step != 2'd0);
    assign advance = !i_empty && (!r_valid || o_out.ready);
    assign o_pop   = advance && is_last;
    assign n_word  = is_nop ? NOP_WORD : i_job.word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step  <= is_last ? 2'd0 : r_step + 2'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_word <= n_word;
            r_kind <= is_nop ? KIND_NOP : i_job.kind;
            r_fmt  <= fmt_of(n_word[6:0]);
            r_imm  <= imm_of(n_word);
            r_hn   <= !is_nop && i_job.haz_near;
            r_hf   <= !is_nop && i_job.haz_far;
            r_last <= is_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.item_kind   = r_kind;
    assign o_out.out_word    = r_word;
    assign o_out.format      = r_fmt;
    assign o_out.dest_reg    = r_word[11:7];
    assign o_out.src1_reg    = r_word[19:15];
    assign o_out.src2_reg    = r_word[24:20];
    assign o_out.imm_bits    = r_imm;
    assign o_out.hazard_near = r_hn;
    assign o_out.hazard_far  = r_hf;
    assign o_out.last        = r_last;
endmodule

/* rtl/riscv_hazard_nop_inserter_top.sv */
// Takes one RV32 instruction word per beat and delivers one result beat per cycle in steady
// state while o_out is ready: the decoded word with its hazard flags, inserted NOPs and
// delay-slot words. A branch or jal in NOP mode, or a delay-slot word that is not a usable
// filler, produces four results, and while these leave the output the two-entry job queue
// between the decode front and the expansion back end fills and input is held off; every
// other input word produces one result. An input beat passes the queue entry and then the
// output register before its first result beat. The user must write branch_mode on the cfg
// channel only while the block is idle; the block itself does not enforce this.
// riscv_hazard_nop_inserter_top: depends on rhni_pkg, rhni_if, rhni_fifo, rhni_front, rhni_back
module riscv_hazard_nop_inserter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhni_in_if.sink    i_in,
    rhni_cfg_if.sink   i_cfg,
    rhni_out_if.source o_out
);
    import rhni_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job front_job;
    t_job back_job;

    rhni_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    rhni_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (back_job)
    );

    rhni_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (back_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
